>>> rtl/core/tcw_pkg.sv
// Package for the text console writer.
// Holds the item payload structs, opcode codes and the controller state type.
// No dependencies.
package tcw_pkg;

  // Width of the position and cursor fields of a result item.
  localparam int POS_W = 11;

  // Character code that moves to the start of the next row.
  localparam logic [7:0] NEWLINE_CODE = 8'd10;

  // Opcodes of an input item.
  localparam logic [1:0] OP_PUT_AT     = 2'd0;
  localparam logic [1:0] OP_PUT_CURSOR = 2'd1;
  localparam logic [1:0] OP_READ       = 2'd2;

  // Reset value of the default attribute register.
  localparam logic [7:0] DEFAULT_COLOR_RESET = 8'd15;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] character;
    logic [7:0] color;
    logic [7:0] column;
    logic [7:0] line;
  } req_t;

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic [POS_W-1:0] cursor;
    logic [7:0]       read_char;
    logic [7:0]       read_color;
    logic             rejected;
  } rsp_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_t;

endpackage

>>> rtl/core/text_console_writer_unit.sv
// Text console writer: character-cell screen memory with a cursor and row scrolling.
// Depends on tcw_pkg for payload structs, opcodes and the state type.
//
// Each item passes through an accept cycle, which latches and decodes it, and a work cycle,
// which accesses the screen memory and loads the result register (ready in the next cycle)
// once no stalled result is pending. A new item is taken only after the last has left the
// work cycle. A put that scrolls then clears one row, and after reset the whole memory of
// COLUMNS*ROWS cells (2000 at the defaults) is cleared, one cell a cycle through its single
// write port, with req_stall high; configuration writes are taken at all times.
module text_console_writer_unit
  import tcw_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  input  logic       req_valid,
  output logic       req_stall,
  input  req_t       req,
  output logic       rsp_valid,
  input  logic       rsp_stall,
  output rsp_t       rsp
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int CW    = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;

  // Linear cell index of a row and column.
  function automatic logic [AW-1:0] cell_index(input logic [RW-1:0] r,
                                               input logic [CW-1:0] c);
    return AW'(r) * AW'(COLUMNS) + AW'(c);
  endfunction

  state_t state;
  state_t state_next;

  logic [7:0]    default_color;

  // Cursor kept as row and column, plus its linear index.
  logic [RW-1:0] crow;
  logic [CW-1:0] ccol;
  logic [AW-1:0] cur_idx;

  // Physical row that holds logical row zero; scrolling advances it.
  logic [RW-1:0] top_row;

  // Clear sweep over the screen memory.
  logic [AW-1:0] clr_addr;
  logic [AW-1:0] clr_end;

  // Decoded item.
  logic          it_put;
  logic          it_read;
  logic          it_ok;
  logic          it_rej;
  logic          it_nl;
  logic [7:0]    it_char;
  logic [7:0]    it_color;
  logic [RW-1:0] it_row;
  logic [CW-1:0] it_col;

  // Result register.
  logic [AW-1:0] rsp_pos;
  logic [AW-1:0] rsp_cur;
  logic          rsp_rej;
  logic          rsp_rd;

  // Screen memory.
  logic [15:0]   mem [CELLS];
  logic [15:0]   rd_data;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [15:0]   mem_wdata;
  logic          mem_re;

  // Controller outputs.
  logic          out_free;
  logic          exec_go;
  logic          clr_we;
  logic          accept;

  // Decode of an incoming item.
  logic          dec_put;
  logic          dec_read;
  logic          dec_ok;
  logic          dec_rej;
  logic          in_range;
  logic [RW-1:0] dec_row;
  logic [CW-1:0] dec_col;

  // Work cycle datapath.
  logic [RW:0]   phys_sum;
  logic [RW-1:0] phys_row;
  logic [AW-1:0] cell_addr;
  logic [RW:0]   nrow_ext;
  logic [RW-1:0] nrow;
  logic [CW-1:0] ncol;
  logic          scroll;
  logic          put_ok;
  logic [RW-1:0] pos_row;
  logic [CW-1:0] pos_col;
  logic [AW-1:0] pos_idx;
  logic [AW-1:0] top_base;

  assign out_free = !rsp_valid || !rsp_stall;
  assign accept   = req_valid && !req_stall;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_addr == clr_end) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (req_valid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (out_free) state_next = scroll ? ST_CLEAR : ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // Controller outputs.
  always_comb begin
    req_stall = 1'b1;
    exec_go   = 1'b0;
    clr_we    = 1'b0;
    case (state)
      ST_CLEAR: clr_we    = 1'b1;
      ST_IDLE:  req_stall = 1'b0;
      ST_EXEC:  exec_go   = out_free;
      default: begin
        req_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLEAR;
    else     state <= state_next;
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst)         default_color <= DEFAULT_COLOR_RESET;
    else if (cfg_we) default_color <= cfg_wdata;
  end

  // Item decode: target cell comes from the fields or from the cursor.
  always_comb begin
    in_range = (req.column < 8'(COLUMNS)) && (req.line < 8'(ROWS));
    dec_put  = 1'b0;
    dec_read = 1'b0;
    dec_ok   = 1'b0;
    dec_rej  = 1'b0;
    dec_row  = RW'(req.line);
    dec_col  = CW'(req.column);
    case (req.opcode)
      OP_PUT_AT: begin
        dec_put = 1'b1;
        dec_ok  = in_range;
        dec_rej = !in_range;
      end
      OP_PUT_CURSOR: begin
        dec_put = 1'b1;
        dec_ok  = 1'b1;
        dec_row = crow;
        dec_col = ccol;
      end
      OP_READ: begin
        dec_read = 1'b1;
        dec_ok   = in_range;
        dec_rej  = !in_range;
      end
      default: begin
        dec_put = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      it_put   <= dec_put;
      it_read  <= dec_read;
      it_ok    <= dec_ok;
      it_rej   <= dec_rej;
      it_nl    <= (req.character == NEWLINE_CODE);
      it_char  <= req.character;
      it_color <= (req.color == 8'd0) ? default_color : req.color;
      it_row   <= dec_row;
      it_col   <= dec_col;
    end
  end

  // Work cycle: physical address, next cursor cell and scroll decision.
  always_comb begin
    phys_sum  = {1'b0, it_row} + {1'b0, top_row};
    phys_row  = (phys_sum >= (RW+1)'(ROWS)) ? RW'(phys_sum - (RW+1)'(ROWS))
                                            : phys_sum[RW-1:0];
    cell_addr = cell_index(phys_row, it_col);

    if (it_nl || (it_col == CW'(COLUMNS - 1))) begin
      nrow_ext = {1'b0, it_row} + (RW+1)'(1);
      ncol     = '0;
    end else begin
      nrow_ext = {1'b0, it_row};
      ncol     = it_col + CW'(1);
    end
    put_ok = it_put && it_ok;
    scroll = put_ok && (nrow_ext == (RW+1)'(ROWS));
    nrow   = (nrow_ext == (RW+1)'(ROWS)) ? RW'(ROWS - 1) : nrow_ext[RW-1:0];

    // A read reports its own cell; a put reports the new cursor cell.
    pos_row  = it_read ? it_row : nrow;
    pos_col  = it_read ? it_col : ncol;
    pos_idx  = cell_index(pos_row, pos_col);
    top_base = cell_index(top_row, CW'(0));
  end

  // Cursor, scroll pointer and clear sweep.
  always_ff @(posedge clk) begin
    if (rst) begin
      crow     <= '0;
      ccol     <= '0;
      cur_idx  <= '0;
      top_row  <= '0;
      clr_addr <= '0;
      clr_end  <= AW'(CELLS - 1);
    end else if (exec_go) begin
      if (put_ok) begin
        crow    <= nrow;
        ccol    <= ncol;
        cur_idx <= pos_idx;
      end
      if (scroll) begin
        // The old top row becomes the bottom row and is cleared.
        top_row  <= (top_row == RW'(ROWS - 1)) ? '0 : top_row + RW'(1);
        clr_addr <= top_base;
        clr_end  <= top_base + AW'(COLUMNS - 1);
      end
    end else if (clr_we && (clr_addr != clr_end)) begin
      clr_addr <= clr_addr + AW'(1);
    end
  end

  // Memory port control. A read never shares a cycle with a write, and any earlier
  // write has already landed, so no forwarding is needed.
  always_comb begin
    mem_we    = clr_we || (exec_go && put_ok && !it_nl);
    mem_waddr = clr_we ? clr_addr : cell_addr;
    mem_wdata = clr_we ? 16'd0 : {it_color, it_char};
    mem_re    = exec_go && it_read && it_ok;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
  end

  always_ff @(posedge clk) begin
    if (mem_re) rd_data <= mem[cell_addr];
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst)                    rsp_valid <= 1'b0;
    else if (exec_go)           rsp_valid <= 1'b1;
    else if (rsp_valid && !rsp_stall) rsp_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (exec_go) begin
      rsp_pos <= (it_ok && (it_put || it_read)) ? pos_idx : '0;
      rsp_cur <= put_ok ? pos_idx : cur_idx;
      rsp_rej <= it_rej;
      rsp_rd  <= it_read && it_ok;
    end
  end

  always_comb begin
    rsp.position   = POS_W'(rsp_pos);
    rsp.cursor     = POS_W'(rsp_cur);
    rsp.read_char  = rsp_rd ? rd_data[7:0] : 8'd0;
    rsp.read_color = rsp_rd ? rd_data[15:8] : 8'd0;
    rsp.rejected   = rsp_rej;
  end

`ifndef SYNTHESIS
  // A new result appears only after a work cycle.
  a_rsp_from_exec: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state) == ST_EXEC)
    else $error("result appeared without a work cycle");

  // The cursor always names a cell on the screen.
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    (crow <= RW'(ROWS - 1)) && (ccol <= CW'(COLUMNS - 1)) && (top_row <= RW'(ROWS - 1)))
    else $error("cursor or top row out of range");

  // The clear sweep never runs past its end.
  a_clear_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_CLEAR |-> clr_addr <= clr_end)
    else $error("clear sweep past its end");

  // A rejected item leaves the cursor where it was.
  a_reject_keeps_cursor: assert property (@(posedge clk) disable iff (rst)
    (exec_go && it_rej) |=> cur_idx == $past(cur_idx))
    else $error("rejected item moved the cursor");

  // Items are taken only while no result of the previous one is pending in the work cycle.
  a_accept_not_busy: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EXEC) |-> req_stall)
    else $error("item taken during the work cycle");
`endif

endmodule
